[rtl/cuem_pkg.sv]
// shared types, constants and helpers of the cpu utilization average monitor
`timescale 1ns / 1ps
`default_nettype none
package cuem_pkg;

  localparam int COUNTER_WIDTH_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int TICK_W       = 64;
  localparam int NUM_COUNTERS = 10;
  localparam int CNT_IDX_W    = 4;
  localparam int SHARE_W      = 15;
  localparam int NUM_SHARES   = 4;
  localparam int NUM_AVGS     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SHARE_W-1:0] FULL_SCALE = 15'd25600;

  // 25600 = 2^14 + 2^13 + 2^10
  localparam int SCALE_SH_A = 14;
  localparam int SCALE_SH_B = 13;
  localparam int SCALE_SH_C = 10;

  localparam logic [CNT_IDX_W-1:0] IDX_USER   = 4'd0;
  localparam logic [CNT_IDX_W-1:0] IDX_SYSTEM = 4'd2;
  localparam logic [CNT_IDX_W-1:0] IDX_IDLE   = 4'd3;
  localparam logic [CNT_IDX_W-1:0] IDX_IOWAIT = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LONG  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // share slot to counter index: iowait first, the averages need it
  function automatic logic [CNT_IDX_W-1:0] share_src(input logic [1:0] slot);
    logic [CNT_IDX_W-1:0] idx;
    unique case (slot)
      2'd0: idx = IDX_IOWAIT;
      2'd1: idx = IDX_USER;
      2'd2: idx = IDX_SYSTEM;
      default: idx = IDX_IDLE;
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

[rtl/cpu_utilization_ema_monitor_unit.sv]
// an item is summed, checked for a zero total, divided per share and then averaged; a zero total skips the rest
// the 15-step shared divider is run once for each of the four shares
// one item at a time: a new item is stalled until the current one is through
// reset clears previous counters, averages, decay factors and all handshake state
// the last result may wait in the output register; the next item then waits at the total check
`timescale 1ns / 1ps
`default_nettype none
module cpu_utilization_ema_monitor_unit #(
  parameter int COUNTER_WIDTH        = cuem_pkg::COUNTER_WIDTH_DEF,
  parameter int FACTOR_FRACTION_BITS = cuem_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cuem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cuem_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [cuem_pkg::TICK_W-1:0]     user_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     nice_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     system_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     idle_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     iowait_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     irq_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     softirq_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     steal_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     guest_ticks_i,
  input  wire logic [cuem_pkg::TICK_W-1:0]     guest_nice_ticks_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [cuem_pkg::SHARE_W-1:0]         iowait_percent_o,
  output logic [cuem_pkg::SHARE_W-1:0]         user_percent_o,
  output logic [cuem_pkg::SHARE_W-1:0]         system_percent_o,
  output logic [cuem_pkg::SHARE_W-1:0]         idle_percent_o,
  output logic [cuem_pkg::SHARE_W-1:0]         iowait_average_short_o,
  output logic [cuem_pkg::SHARE_W-1:0]         iowait_average_mid_o,
  output logic [cuem_pkg::SHARE_W-1:0]         iowait_average_long_o,
  output logic                                 no_ticks_o
);

  localparam int CW = COUNTER_WIDTH;
  localparam int TW = CW + 4;
  localparam int NW = CW + cuem_pkg::SHARE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_NUM   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMA   = 3'd6;
  localparam logic [2:0] S_EMAW  = 3'd7;

  localparam logic [cuem_pkg::CNT_IDX_W-1:0] LastCnt =
    cuem_pkg::CNT_IDX_W'(cuem_pkg::NUM_COUNTERS - 1);
  localparam logic [1:0] LastShare = 2'(cuem_pkg::NUM_SHARES - 1);
  localparam logic [1:0] LastAvg   = 2'(cuem_pkg::NUM_AVGS - 1);

  logic [cuem_pkg::TICK_W-1:0]   ticks [cuem_pkg::NUM_COUNTERS];
  logic [CW-1:0]                 prev_q  [cuem_pkg::NUM_COUNTERS];
  logic [CW-1:0]                 prev_d  [cuem_pkg::NUM_COUNTERS];
  logic [CW-1:0]                 delta_q [cuem_pkg::NUM_COUNTERS];
  logic [CW-1:0]                 delta_d [cuem_pkg::NUM_COUNTERS];
  logic [cuem_pkg::SHARE_W-1:0]  sh_q  [cuem_pkg::NUM_SHARES];
  logic [cuem_pkg::SHARE_W-1:0]  sh_d  [cuem_pkg::NUM_SHARES];
  logic [cuem_pkg::SHARE_W-1:0]  avg_q [cuem_pkg::NUM_AVGS];
  logic [cuem_pkg::SHARE_W-1:0]  avg_d [cuem_pkg::NUM_AVGS];
  logic [cuem_pkg::CFG_DATA_W-1:0] fac_q [cuem_pkg::NUM_AVGS];

  logic [2:0]                         state_q, state_d;
  logic [cuem_pkg::CNT_IDX_W-1:0]     cnt_q, cnt_d;
  logic [1:0]                         slot_q, slot_d;
  logic [TW-1:0]                      total_q, total_d;
  logic [NW-1:0]                      num_q, num_d;
  logic [CW-1:0]                      dsel;
  logic                               notick_q, notick_d;
  logic                               accept, load_out;
  logic                               out_free;

  logic                               out_valid_q, out_valid_d;
  logic [cuem_pkg::SHARE_W-1:0]       o_sh_q  [cuem_pkg::NUM_SHARES];
  logic [cuem_pkg::SHARE_W-1:0]       o_avg_q [cuem_pkg::NUM_AVGS];
  logic                               o_notick_q;

  cuem_pkg::div_stat_t                div_stat;
  logic [cuem_pkg::SHARE_W-1:0]       div_quot;
  logic                               ema_start, ema_valid;
  logic [cuem_pkg::SHARE_W-1:0]       ema_avg;

  assign ticks[0] = user_ticks_i;
  assign ticks[1] = nice_ticks_i;
  assign ticks[2] = system_ticks_i;
  assign ticks[3] = idle_ticks_i;
  assign ticks[4] = iowait_ticks_i;
  assign ticks[5] = irq_ticks_i;
  assign ticks[6] = softirq_ticks_i;
  assign ticks[7] = steal_ticks_i;
  assign ticks[8] = guest_ticks_i;
  assign ticks[9] = guest_nice_ticks_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // output register empty or handing its item over at this edge
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_EMAW) && ema_valid && (slot_q == LastAvg) ||
                      (state_q == S_CHECK) && (total_q == '0) && out_free;

  assign dsel = delta_q[cuem_pkg::share_src(slot_q)];
  assign ema_start = (state_q == S_EMA);

  cuem_divider #(
    .NUM_W (NW),
    .DEN_W (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .num_i   (num_q),
    .den_i   (total_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  cuem_ema #(
    .FRAC_BITS (FACTOR_FRACTION_BITS)
  ) u_ema (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ema_start),
    .cur_i    (sh_q[0]),
    .avg_i    (avg_q[slot_q]),
    .factor_i (fac_q[slot_q]),
    .valid_o  (ema_valid),
    .avg_o    (ema_avg)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    slot_d   = slot_q;
    total_d  = total_q;
    num_d    = num_q;
    notick_d = notick_q;
    prev_d   = prev_q;
    delta_d  = delta_q;
    sh_d     = sh_q;
    avg_d    = avg_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < cuem_pkg::NUM_COUNTERS; i++) begin
            delta_d[i] = ticks[i][CW-1:0] - prev_q[i];
            prev_d[i]  = ticks[i][CW-1:0];
          end
          total_d = '0;
          cnt_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        total_d = total_q + TW'(delta_q[cnt_q]);
        if (cnt_q == LastCnt) begin
          state_d = S_CHECK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CHECK: begin
        // wait here while the previous result is still held
        if (out_free) begin
          if (total_q == '0) begin
            for (int i = 0; i < cuem_pkg::NUM_SHARES; i++) sh_d[i] = '0;
            for (int i = 0; i < cuem_pkg::NUM_AVGS; i++) avg_d[i] = '0;
            notick_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            notick_d = 1'b0;
            slot_d   = '0;
            state_d  = S_NUM;
          end
        end
      end
      S_NUM: begin
        num_d = (NW'(dsel) << cuem_pkg::SCALE_SH_A) + (NW'(dsel) << cuem_pkg::SCALE_SH_B)
              + (NW'(dsel) << cuem_pkg::SCALE_SH_C);
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          sh_d[slot_q] = div_quot;
          if (slot_q == LastShare) begin
            slot_d  = '0;
            state_d = S_EMA;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_NUM;
          end
        end
      end
      S_EMA: begin
        state_d = S_EMAW;
      end
      S_EMAW: begin
        if (ema_valid) begin
          avg_d[slot_q] = ema_avg;
          if (slot_q == LastAvg) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_EMA;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // staging happens as the core finishes; the core only finishes with the register free
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      notick_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < cuem_pkg::NUM_COUNTERS; i++) prev_q[i] <= '0;
      for (int i = 0; i < cuem_pkg::NUM_AVGS; i++) begin
        avg_q[i] <= '0;
        fac_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      notick_q    <= notick_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      avg_q       <= avg_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cuem_pkg::REG_DECAY_SHORT: fac_q[0] <= cfg_wdata_i;
          cuem_pkg::REG_DECAY_MID:   fac_q[1] <= cfg_wdata_i;
          cuem_pkg::REG_DECAY_LONG:  fac_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    num_q   <= num_d;
    delta_q <= delta_d;
    sh_q    <= sh_d;
  end

  // zero-total results come straight from the cleared values
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < cuem_pkg::NUM_SHARES; i++) o_sh_q[i] <= sh_d[i];
      for (int i = 0; i < cuem_pkg::NUM_AVGS; i++) o_avg_q[i] <= avg_d[i];
      o_notick_q <= notick_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign iowait_percent_o       = o_sh_q[0];
  assign user_percent_o         = o_sh_q[1];
  assign system_percent_o       = o_sh_q[2];
  assign idle_percent_o         = o_sh_q[3];
  assign iowait_average_short_o = o_avg_q[0];
  assign iowait_average_mid_o   = o_avg_q[1];
  assign iowait_average_long_o  = o_avg_q[2];
  assign no_ticks_o             = o_notick_q;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> state_q == S_DIV)
    else $error("divider active outside the divide step");

  a_ema_valid_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ema_valid |-> state_q == S_EMAW)
    else $error("average result outside the wait step");

  a_no_ticks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_ticks_o |-> iowait_percent_o == '0 && user_percent_o == '0 &&
      iowait_average_short_o == '0 && iowait_average_long_o == '0)
    else $error("zero-total item carries nonzero values");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iowait_average_short_o <= cuem_pkg::FULL_SCALE &&
      iowait_average_mid_o <= cuem_pkg::FULL_SCALE &&
      iowait_average_long_o <= cuem_pkg::FULL_SCALE)
    else $error("average beyond full scale");

  a_finish_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o && state_q == S_IDLE)
    else $error("finished item not staged");

  a_stage_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("held result overwritten");
`endif

endmodule
`default_nettype wire

[rtl/cuem_divider.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cuem_divider #(
  parameter int NUM_W = 79,
  parameter int DEN_W = 68
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [DEN_W-1:0]              den_i,
  output cuem_pkg::div_stat_t                stat_o,
  output logic [cuem_pkg::SHARE_W-1:0]       quot_o
);

  localparam int W     = DEN_W + cuem_pkg::SHARE_W - 1;
  localparam int CNT_W = $clog2(cuem_pkg::SHARE_W + 1);
  localparam logic [CNT_W-1:0] StepCount = CNT_W'(cuem_pkg::SHARE_W);
  localparam logic [CNT_W-1:0] LastStep  = CNT_W'(1);

  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  dsh_q, dsh_d;
  logic [cuem_pkg::SHARE_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = W'(num_i);
      dsh_d  = W'(den_i) << (cuem_pkg::SHARE_W - 1);
      quot_d = '0;
      cnt_d  = StepCount;
    end else if (cnt_q != '0) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[cuem_pkg::SHARE_W-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[cuem_pkg::SHARE_W-2:0], 1'b0};
      end
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - LastStep;
      done_d = (cnt_q == LastStep);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule
`default_nettype wire

[rtl/cuem_ema.sv]
// shared average update: multiply, round, add and clamp over two stages
`timescale 1ns / 1ps
`default_nettype none
module cuem_ema #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic [cuem_pkg::SHARE_W-1:0]       cur_i,
  input  wire logic [cuem_pkg::SHARE_W-1:0]       avg_i,
  input  wire logic [cuem_pkg::CFG_DATA_W-1:0]    factor_i,
  output logic                                    valid_o,
  output logic [cuem_pkg::SHARE_W-1:0]            avg_o
);

  localparam int FW = (FRAC_BITS + 1 > cuem_pkg::CFG_DATA_W) ? FRAC_BITS + 1
                                                              : cuem_pkg::CFG_DATA_W;
  localparam int PW = FW + 1 + cuem_pkg::SHARE_W + 1;
  localparam logic [FW-1:0]        One  = FW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] Top  = PW'(cuem_pkg::FULL_SCALE);

  logic [FW-1:0]                     fac_ext, fac_sat;
  logic [cuem_pkg::SHARE_W-1:0]      avg_c;
  logic signed [cuem_pkg::SHARE_W:0] diff;
  logic signed [PW-1:0]              prod_q, prod_d;
  logic [cuem_pkg::SHARE_W-1:0]      cur_q;
  logic                              v1_q, v2_q;
  logic signed [PW-1:0]              rsum, rsh, rval;
  logic [cuem_pkg::SHARE_W-1:0]      res_q, res_d;

  always_comb begin
    fac_ext = FW'(factor_i);
    fac_sat = (fac_ext > One) ? One : fac_ext;
    avg_c   = (avg_i > cuem_pkg::FULL_SCALE) ? cuem_pkg::FULL_SCALE : avg_i;
    diff    = $signed({1'b0, avg_c}) - $signed({1'b0, cur_i});
    prod_d  = PW'($signed({1'b0, fac_sat})) * PW'(diff);
  end

  // floor of (f*d + half) / 2^frac is round to nearest, ties up
  always_comb begin
    rsum = prod_q + Half;
    rsh  = rsum >>> FRAC_BITS;
    rval = rsh + PW'($signed({1'b0, cur_q}));
    if (rval < 0) begin
      res_d = '0;
    end else if (rval > Top) begin
      res_d = cuem_pkg::FULL_SCALE;
    end else begin
      res_d = rval[cuem_pkg::SHARE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    cur_q  <= cur_i;
    res_q  <= res_d;
  end

  assign valid_o = v2_q;
  assign avg_o   = res_q;

endmodule
`default_nettype wire
